@@ src/cmbe_pkg.sv @@
// ----------------------------------------------------------------------------
// cmbe_pkg
// Shared types and constants for the clipped monochrome bitmap expand blit.
// ----------------------------------------------------------------------------
`default_nettype none

package cmbe_pkg;

  // register indexes on the configuration port
  localparam logic [2:0] REG_IMAGE_LEFT  = 3'd0;
  localparam logic [2:0] REG_IMAGE_TOP   = 3'd1;
  localparam logic [2:0] REG_BITMAP_WIDE = 3'd2;
  localparam logic [2:0] REG_CLIP_LEFT   = 3'd3;
  localparam logic [2:0] REG_CLIP_TOP    = 3'd4;
  localparam logic [2:0] REG_CLIP_WIDE   = 3'd5;
  localparam logic [2:0] REG_CLIP_TALL   = 3'd6;
  localparam logic [2:0] REG_COLOUR_PAIR = 3'd7;

  // rotation codes
  localparam logic [1:0] ROT_0   = 2'd0;
  localparam logic [1:0] ROT_90  = 2'd1;
  localparam logic [1:0] ROT_180 = 2'd2;
  localparam logic [1:0] ROT_270 = 2'd3;

  localparam logic [11:0] MAX_BITMAP_WIDE = 12'd2048;

  typedef struct packed {
    logic [7:0] mono_byte;
    logic       last_byte;
  } cmbe_in_t;

  typedef struct packed {
    logic [16:0] pixel_address;
    logic [23:0] pixel_rgb;
    logic        last_of_byte;
  } cmbe_out_t;

  typedef struct packed {
    logic signed [15:0] image_left;
    logic signed [15:0] image_top;
    logic [11:0]        bitmap_pixels_wide;
    logic signed [15:0] clip_left;
    logic signed [15:0] clip_top;
    logic [14:0]        clip_wide;
    logic [14:0]        clip_tall;
    logic [47:0]        colour_pair;
  } cmbe_cfg_t;

  // one decoded byte: which of its eight pixels are written, and the
  // signed framebuffer address of its leftmost pixel
  typedef struct packed {
    logic [7:0]         mask;
    logic [7:0]         data;
    logic signed [31:0] base;
  } cmbe_job_t;

endpackage

`default_nettype wire

@@ src/cmbe_regs.sv @@
// ----------------------------------------------------------------------------
// cmbe_regs
// Configuration register file, written through a valid/ready port.
// ----------------------------------------------------------------------------
`default_nettype none

module cmbe_regs
  import cmbe_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [47:0] cfg_data,
  output cmbe_cfg_t        cfg
);

  cmbe_cfg_t cfg_r;
  cmbe_cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        REG_IMAGE_LEFT:  cfg_nxt.image_left         = signed'(cfg_data[15:0]);
        REG_IMAGE_TOP:   cfg_nxt.image_top          = signed'(cfg_data[15:0]);
        REG_BITMAP_WIDE: cfg_nxt.bitmap_pixels_wide = cfg_data[11:0];
        REG_CLIP_LEFT:   cfg_nxt.clip_left          = signed'(cfg_data[15:0]);
        REG_CLIP_TOP:    cfg_nxt.clip_top           = signed'(cfg_data[15:0]);
        REG_CLIP_WIDE:   cfg_nxt.clip_wide          = cfg_data[14:0];
        REG_CLIP_TALL:   cfg_nxt.clip_tall          = cfg_data[14:0];
        REG_COLOUR_PAIR: cfg_nxt.colour_pair        = cfg_data;
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.image_left         <= 16'sd0;
      cfg_r.image_top          <= 16'sd0;
      cfg_r.bitmap_pixels_wide <= 12'd8;
      cfg_r.clip_left          <= 16'sd0;
      cfg_r.clip_top           <= 16'sd0;
      cfg_r.clip_wide          <= 15'd240;
      cfg_r.clip_tall          <= 15'd320;
      cfg_r.colour_pair        <= 48'hFF_FFFF;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

`default_nettype wire

@@ src/cmbe_front.sv @@
// ----------------------------------------------------------------------------
// cmbe_front
// Input register and byte decode: tracks row and byte position, clips the
// eight pixels of the held byte and computes the address of its first pixel.
// ----------------------------------------------------------------------------
`default_nettype none

module cmbe_front
  import cmbe_pkg::*;
#(
  parameter int PANEL_WIDTH  = 240,
  parameter int PANEL_HEIGHT = 320,
  parameter int ROTATION     = 0
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  cmbe_cfg_t      cfg,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  cmbe_in_t       in_data,
  input  wire logic      load_ok,
  output logic           job_valid,
  output cmbe_job_t      job
);

  localparam logic [1:0]         ROT  = 2'(ROTATION);
  localparam logic signed [31:0] PW_S = 32'(PANEL_WIDTH);
  localparam logic signed [31:0] PH_S = 32'(PANEL_HEIGHT);

  logic        s1_valid_r, s1_valid_nxt;
  logic [7:0]  s1_data_r;
  logic [15:0] s1_row_r;
  logic [8:0]  s1_byte_r;
  logic [15:0] row_r, row_nxt;
  logic [8:0]  byte_r, byte_nxt;

  logic        accept;
  logic [11:0] width_sat;
  logic [8:0]  bytes_per_row;

  assign in_stall  = s1_valid_r && !load_ok;
  assign accept    = in_valid && !in_stall;
  assign job_valid = s1_valid_r;

  assign width_sat     = (cfg.bitmap_pixels_wide > MAX_BITMAP_WIDE) ?
                         MAX_BITMAP_WIDE : cfg.bitmap_pixels_wide;
  assign bytes_per_row = 9'((13'(width_sat) + 13'd7) >> 3);

  // position of the next byte
  always_comb begin
    row_nxt  = row_r;
    byte_nxt = byte_r;
    if (accept) begin
      if (in_data.last_byte) begin
        row_nxt  = '0;
        byte_nxt = '0;
      end else if ((10'(byte_r) + 10'd1) >= 10'(bytes_per_row)) begin
        byte_nxt = '0;
        row_nxt  = row_r + 16'd1;
      end else begin
        byte_nxt = byte_r + 9'd1;
      end
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (load_ok) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      row_r      <= '0;
      byte_r     <= '0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      row_r      <= row_nxt;
      byte_r     <= byte_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_data_r <= in_data.mono_byte;
      s1_row_r  <= row_r;
      s1_byte_r <= byte_r;
    end
  end

  // clip tests per pixel, rotation and base address
  always_comb begin
    logic signed [31:0] sy;
    logic signed [31:0] cl;
    logic signed [31:0] ct;
    logic signed [31:0] cr;
    logic signed [31:0] cb;
    logic signed [31:0] sx;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic [11:0]        col;
    logic               row_in;
    sy     = 32'(cfg.image_top) + signed'({16'd0, s1_row_r});
    cl     = 32'(cfg.clip_left);
    ct     = 32'(cfg.clip_top);
    cr     = cl + signed'({17'd0, cfg.clip_wide});
    cb     = ct + signed'({17'd0, cfg.clip_tall});
    row_in = (sy >= ct) && (sy < cb);
    job.data = s1_data_r;
    job.mask = '0;
    job.base = '0;
    for (int k = 0; k < 8; k++) begin
      col = {s1_byte_r, 3'(k)};
      sx  = 32'(cfg.image_left) + signed'({20'd0, col});
      case (ROT)
        ROT_0: begin
          px = sx;
          py = sy;
        end
        ROT_90: begin
          px = sy;
          py = PH_S - 32'sd1 - sx;
        end
        ROT_180: begin
          px = PW_S - 32'sd1 - sx;
          py = PH_S - 32'sd1 - sy;
        end
        default: begin
          px = PW_S - 32'sd1 - sy;
          py = sx;
        end
      endcase
      job.mask[k] = row_in && (col < width_sat) && (sx >= cl) && (sx < cr) &&
                    (px >= 32'sd0) && (px < PW_S) && (py >= 32'sd0) && (py < PH_S);
      if (k == 0) begin
        job.base = py * PW_S + px;
      end
    end
  end

endmodule

`default_nettype wire

@@ src/cmbe_expand.sv @@
// ----------------------------------------------------------------------------
// cmbe_expand
// Pixel serializer and output register: emits the clipped pixels of one
// decoded byte left to right, one pixel write per cycle while out_stall is low.
// ----------------------------------------------------------------------------
`default_nettype none

module cmbe_expand
  import cmbe_pkg::*;
#(
  parameter int PANEL_WIDTH = 240,
  parameter int ROTATION    = 0
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  cmbe_cfg_t      cfg,
  input  wire logic      job_valid,
  input  cmbe_job_t      job,
  output logic           load_ok,
  output logic           out_valid,
  input  wire logic      out_stall,
  output cmbe_out_t      out_data
);

  localparam logic [1:0]         ROT  = 2'(ROTATION);
  localparam logic signed [31:0] PW_S = 32'(PANEL_WIDTH);

  logic [7:0]         mask_r, mask_nxt;
  logic [7:0]         data_r;
  logic signed [31:0] base_r;
  logic               out_valid_r;
  cmbe_out_t          out_r, out_nxt;

  logic               busy;
  logic               out_free;
  logic               emit;
  logic               load;
  logic [2:0]         pick;
  logic [7:0]         pick_oh;
  logic [7:0]         remaining;
  logic               last;
  logic signed [31:0] offset;
  logic signed [31:0] addr;

  assign busy      = mask_r != 8'd0;
  assign out_free  = !out_valid_r || !out_stall;
  assign emit      = busy && out_free;
  assign pick_oh   = 8'd1 << pick;
  assign remaining = mask_r & ~pick_oh;
  assign last      = remaining == 8'd0;
  assign load_ok   = !busy || (emit && last);
  assign load      = job_valid && load_ok;

  // leftmost pending pixel
  always_comb begin
    pick = 3'd0;
    for (int k = 7; k >= 0; k--) begin
      if (mask_r[k]) begin
        pick = 3'(k);
      end
    end
  end

  always_comb begin
    case (ROT)
      ROT_0:   offset = signed'({29'd0, pick});
      ROT_90:  offset = -(signed'({29'd0, pick}) * PW_S);
      ROT_180: offset = -signed'({29'd0, pick});
      default: offset = signed'({29'd0, pick}) * PW_S;
    endcase
    addr = base_r + offset;
    out_nxt.pixel_address = addr[16:0];
    out_nxt.pixel_rgb     = data_r[3'd7 - pick] ? cfg.colour_pair[47:24] :
                                                  cfg.colour_pair[23:0];
    out_nxt.last_of_byte  = last;
  end

  always_comb begin
    mask_nxt = mask_r;
    if (load) begin
      mask_nxt = job.mask;
    end else if (emit) begin
      mask_nxt = remaining;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      mask_r <= mask_nxt;
      if (out_free) begin
        out_valid_r <= emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= job.data;
      base_r <= job.base;
    end
    if (emit) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // a byte with pixels left keeps the serializer busy
  a_busy_after_mid: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && !last) |=> busy)
    else $error("serializer idle with pixels pending");

  // without a load the pending set only loses bits
  a_mask_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    (busy && !load) |=> ((mask_r & ~$past(mask_r)) == 8'd0))
    else $error("pending pixel set grew without a load");

  // a stalled output freezes the pending set
  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (busy && !out_free) |=> (mask_r == $past(mask_r)))
    else $error("pixel dropped while output stalled");

  // last_of_byte marks the pixel that frees the serializer
  a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && last && !job_valid) |=> !busy)
    else $error("serializer still busy after final pixel");

endmodule

`default_nettype wire

@@ src/clipped_mono_bitmap_expand_blit.sv @@
// ----------------------------------------------------------------------------
// clipped_mono_bitmap_expand_blit
// Expands bytes of a 1-bit-per-pixel bitmap into clipped, rotated pixel
// writes addressed into a framebuffer.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : bitmap bytes in row order, msb leftmost, last_byte on the final
//           byte of a bitmap (row and byte position return to zero after it).
//   out_* : one framebuffer write per transfer, pixels of a byte left to
//           right, last_of_byte on the final write caused by that byte.
//   cfg_* : register writes, always ready; write only while the block is idle.
// Path: the first pixel of a byte goes from the input register through the
//   serializer to the output register. Throughput: one pixel write per cycle
//   while out_stall is low; the serializer feeding the output register sets
//   this. A byte yields up to eight writes; one that yields none still passes
//   through the serializer. The next byte is taken and decoded while the current one drains.
// Reset: synchronous, active low; position and valids clear, registers take
//   their reset values. A stall on out_stall holds out_data and, once the
//   input register is full, raises in_stall.
// ----------------------------------------------------------------------------
`default_nettype none

module clipped_mono_bitmap_expand_blit
  import cmbe_pkg::*;
#(
  parameter int PANEL_WIDTH  = 240,
  parameter int PANEL_HEIGHT = 320,
  parameter int ROTATION     = 0
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  cmbe_in_t         in_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output cmbe_out_t        out_data,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [47:0] cfg_data
);

  cmbe_cfg_t cfg;
  cmbe_job_t job;
  logic      job_valid;
  logic      load_ok;

  cmbe_regs u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  cmbe_front #(
    .PANEL_WIDTH  (PANEL_WIDTH),
    .PANEL_HEIGHT (PANEL_HEIGHT),
    .ROTATION     (ROTATION)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .load_ok   (load_ok),
    .job_valid (job_valid),
    .job       (job)
  );

  cmbe_expand #(
    .PANEL_WIDTH (PANEL_WIDTH),
    .ROTATION    (ROTATION)
  ) u_expand (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .job_valid (job_valid),
    .job       (job),
    .load_ok   (load_ok),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

@@ tb/sv/clipped_mono_bitmap_expand_blit_tb.sv @@
// ----------------------------------------------------------------------------
// clipped_mono_bitmap_expand_blit_tb
// Feeds bitmap bytes and register settings to the blit and checks every pixel
// write against a bit-exact predictor of clipping, rotation and addressing.
// ----------------------------------------------------------------------------
module clipped_mono_bitmap_expand_blit_tb
  import cmbe_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PANEL_WIDTH   = 240;
  localparam int PANEL_HEIGHT  = 320;
  localparam int ROTATION      = 0;
  localparam int SETTLE_CYCLES = 12;
  localparam int STALL_LIMIT   = 2000;
  localparam int RANDOM_BYTES  = 330;

  // predicted pixel writes of the blit, checked in order
  class blit_scoreboard;
    cmbe_cfg_t   regs;
    logic [15:0] row_q;
    logic [8:0]  col_byte_q;
    cmbe_out_t   pending_writes[$];
    int          errors;

    function new();
      regs.image_left         = '0;
      regs.image_top          = '0;
      regs.bitmap_pixels_wide = 12'd8;
      regs.clip_left          = '0;
      regs.clip_top           = '0;
      regs.clip_wide          = 15'd240;
      regs.clip_tall          = 15'd320;
      regs.colour_pair        = 48'hFF_FFFF;
      row_q                   = '0;
      col_byte_q              = '0;
      errors                  = 0;
    endfunction

    function void note_register(logic [2:0] idx, logic [47:0] value);
      case (idx)
        REG_IMAGE_LEFT:  regs.image_left = value[15:0];
        REG_IMAGE_TOP:   regs.image_top = value[15:0];
        REG_BITMAP_WIDE: regs.bitmap_pixels_wide = value[11:0];
        REG_CLIP_LEFT:   regs.clip_left = value[15:0];
        REG_CLIP_TOP:    regs.clip_top = value[15:0];
        REG_CLIP_WIDE:   regs.clip_wide = value[14:0];
        REG_CLIP_TALL:   regs.clip_tall = value[14:0];
        REG_COLOUR_PAIR: regs.colour_pair = value;
        default: ;
      endcase
    endfunction

    // expands one accepted byte into its expected writes, then moves the position
    function void take_byte(cmbe_in_t item);
      int        width;
      int        per_row;
      int        col;
      int        sx;
      int        sy;
      int        px;
      int        py;
      int        lo_x;
      int        lo_y;
      cmbe_out_t pix;
      cmbe_out_t found[$];
      width   = (regs.bitmap_pixels_wide > MAX_BITMAP_WIDE) ? int'(MAX_BITMAP_WIDE)
                                                             : int'(regs.bitmap_pixels_wide);
      per_row = (width + 7) / 8;
      lo_x    = int'(regs.clip_left);
      lo_y    = int'(regs.clip_top);
      sy      = int'(regs.image_top) + int'(row_q);
      if (sy >= lo_y && sy < lo_y + int'(regs.clip_tall)) begin
        for (int k = 0; k < 8; k++) begin
          col = int'(col_byte_q) * 8 + k;
          if (col >= width) break;
          sx = int'(regs.image_left) + col;
          if (sx < lo_x || sx >= lo_x + int'(regs.clip_wide)) continue;
          case (2'(ROTATION))
            ROT_0: begin
              px = sx;
              py = sy;
            end
            ROT_90: begin
              px = sy;
              py = PANEL_HEIGHT - 1 - sx;
            end
            ROT_180: begin
              px = PANEL_WIDTH - 1 - sx;
              py = PANEL_HEIGHT - 1 - sy;
            end
            default: begin
              px = PANEL_WIDTH - 1 - sy;
              py = sx;
            end
          endcase
          if (px < 0 || px >= PANEL_WIDTH || py < 0 || py >= PANEL_HEIGHT) continue;
          pix.pixel_address = 17'(py * PANEL_WIDTH + px);
          pix.pixel_rgb     = item.mono_byte[7 - k] ? regs.colour_pair[47:24]
                                                    : regs.colour_pair[23:0];
          pix.last_of_byte  = 1'b0;
          found.push_back(pix);
        end
      end
      if (found.size() > 0) begin
        pix = found.pop_back();
        pix.last_of_byte = 1'b1;
        found.push_back(pix);
      end
      foreach (found[i]) pending_writes.push_back(found[i]);

      if (item.last_byte) begin
        row_q      = '0;
        col_byte_q = '0;
      end else if (int'(col_byte_q) + 1 >= per_row) begin
        col_byte_q = '0;
        row_q      = row_q + 16'd1;
      end else begin
        col_byte_q = col_byte_q + 9'd1;
      end
    endfunction

    task report(string what);
      $display("mismatch: %s", what);
      errors++;
    endtask

    task check_pixel_write(cmbe_out_t got);
      cmbe_out_t want;
      if (pending_writes.size() == 0) begin
        report($sformatf("unexpected pixel write addr %0d color %06h",
                         got.pixel_address, got.pixel_rgb));
        return;
      end
      want = pending_writes.pop_front();
      if (got.pixel_address !== want.pixel_address)
        report($sformatf("pixel_address got %0d want %0d",
                         got.pixel_address, want.pixel_address));
      if (got.pixel_rgb !== want.pixel_rgb)
        report($sformatf("pixel_rgb at %0d got %06h want %06h",
                         want.pixel_address, got.pixel_rgb, want.pixel_rgb));
      if (got.last_of_byte !== want.last_of_byte)
        report($sformatf("last_of_byte at %0d got %b want %b",
                         want.pixel_address, got.last_of_byte, want.last_of_byte));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  cmbe_in_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  cmbe_out_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = REG_IMAGE_LEFT;
  logic [47:0] cfg_data = '0;
  logic        quiet = 1'b0;
  int          idle_cycles = 0;

  blit_scoreboard sb = new();

  clipped_mono_bitmap_expand_blit #(
    .PANEL_WIDTH (PANEL_WIDTH),
    .PANEL_HEIGHT(PANEL_HEIGHT),
    .ROTATION    (ROTATION)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ends the run when nothing has moved for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // framebuffer side: random stall before each write transfer
  initial begin : pixel_sink
    int hold;
    wait (rst_n === 1'b1);
    forever begin
      hold = quiet ? 0 : $urandom_range(0, 3);
      repeat (hold) begin
        @(negedge clk);
        out_stall <= 1'b1;
      end
      @(negedge clk);
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
      sb.check_pixel_write(out_data);
    end
  end

  task automatic program_register(input logic [2:0] idx, input logic [47:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    sb.note_register(idx, value);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic load_settings(input cmbe_cfg_t s);
    program_register(REG_IMAGE_LEFT,  {32'd0, s.image_left});
    program_register(REG_IMAGE_TOP,   {32'd0, s.image_top});
    program_register(REG_BITMAP_WIDE, {36'd0, s.bitmap_pixels_wide});
    program_register(REG_CLIP_LEFT,   {32'd0, s.clip_left});
    program_register(REG_CLIP_TOP,    {32'd0, s.clip_top});
    program_register(REG_CLIP_WIDE,   {33'd0, s.clip_wide});
    program_register(REG_CLIP_TALL,   {33'd0, s.clip_tall});
    program_register(REG_COLOUR_PAIR, s.colour_pair);
  endtask

  task automatic send_byte(input logic [7:0] image, input logic fin);
    cmbe_in_t item;
    int       gap;
    item.mono_byte = image;
    item.last_byte = fin;
    gap = quiet ? 0 : $urandom_range(0, 3);
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
    sb.take_byte(item);
  endtask

  // let every pending write arrive, then give a byte with no writes time to retire
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending_writes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    cmbe_cfg_t s;
    int        w;
    int        per_row;
    int        n;
    int        sent;
    logic      broken;
    logic      fin;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: each byte is one 8 pixel row
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hA5, 1'b0);
    send_byte(8'h5A, 1'b1);
    drain();

    // straddles the right panel edge and the top, 12 wide so the pad bits drop
    s = sb.regs;
    s.image_left         = 16'sd236;
    s.image_top          = -16'sd1;
    s.bitmap_pixels_wide = 12'd12;
    s.clip_left          = -16'sd10;
    s.clip_top           = -16'sd10;
    s.clip_wide          = 15'h7FFF;
    s.clip_tall          = 15'h7FFF;
    s.colour_pair        = '1;
    load_settings(s);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h0F, 1'b0);
    send_byte(8'h81, 1'b0);
    send_byte(8'hF0, 1'b1);
    drain();

    // coordinate extremes, clip sums must not wrap
    s.image_left         = 16'sh7FFF;
    s.image_top          = 16'sh7FFF;
    s.clip_left          = 16'sh7FFF;
    s.clip_top           = 16'sh7FFF;
    s.bitmap_pixels_wide = 12'd8;
    s.colour_pair        = '0;
    load_settings(s);
    send_byte(8'h3C, 1'b0);
    send_byte(8'hC3, 1'b1);
    drain();
    s.image_left = 16'sh8000;
    s.image_top  = 16'sh8000;
    s.clip_left  = 16'sh8000;
    s.clip_top   = 16'sh8000;
    load_settings(s);
    send_byte(8'h96, 1'b0);
    send_byte(8'h69, 1'b1);
    drain();

    // zero width: every byte is a row, then a 1 wide row lands on y 0
    s.image_left         = '0;
    s.image_top          = '0;
    s.clip_left          = '0;
    s.clip_top           = '0;
    s.clip_wide          = 15'd240;
    s.clip_tall          = 15'd320;
    s.bitmap_pixels_wide = '0;
    s.colour_pair        = 48'h123456_ABCDEF;
    load_settings(s);
    repeat (3) send_byte(8'hFF, 1'b0);
    drain();
    s.bitmap_pixels_wide = 12'd1;
    s.image_top          = -16'sd3;
    load_settings(s);
    send_byte(8'h80, 1'b1);
    drain();

    // empty clip window in each direction
    s.image_top          = '0;
    s.bitmap_pixels_wide = 12'd8;
    s.clip_wide          = '0;
    load_settings(s);
    send_byte(8'hFF, 1'b0);
    drain();
    s.clip_wide = 15'd240;
    s.clip_tall = '0;
    load_settings(s);
    send_byte(8'h00, 1'b1);
    drain();

    // narrowing the width leaves the position past the row end
    s.clip_tall          = 15'd320;
    s.bitmap_pixels_wide = 12'd24;
    load_settings(s);
    send_byte(8'h11, 1'b0);
    send_byte(8'h22, 1'b0);
    drain();
    s.bitmap_pixels_wide = 12'd8;
    load_settings(s);
    send_byte(8'h33, 1'b0);
    send_byte(8'hE7, 1'b1);
    drain();

    // width above the maximum, then a narrow clip slice
    s.bitmap_pixels_wide = 12'hFFF;
    s.image_left         = -16'sd8;
    load_settings(s);
    send_byte(8'h55, 1'b0);
    send_byte(8'hAA, 1'b1);
    drain();
    s.bitmap_pixels_wide = 12'd8;
    s.image_left         = '0;
    s.clip_left          = 16'sd3;
    s.clip_wide          = 15'd3;
    load_settings(s);
    send_byte(8'hFF, 1'b1);
    drain();

    // random bitmaps over random settings, mostly on the panel
    sent = 0;
    for (int p = 0; sent < RANDOM_BYTES; p++) begin
      quiet = (p % 5 == 4);
      s.image_left         = 16'($urandom_range(0, 280) - 30);
      s.image_top          = 16'($urandom_range(0, 360) - 30);
      s.bitmap_pixels_wide = 12'($urandom_range(1, 24));
      s.clip_left          = 16'($urandom_range(0, 220) - 20);
      s.clip_top           = 16'($urandom_range(0, 300) - 20);
      s.clip_wide          = 15'($urandom_range(0, 260));
      s.clip_tall          = 15'($urandom_range(0, 340));
      s.colour_pair        = 48'({$urandom, $urandom});
      if ($urandom_range(0, 5) == 0) begin
        case ($urandom_range(0, 4))
          0:       s.bitmap_pixels_wide = '0;
          1:       s.bitmap_pixels_wide = 12'd2047;
          2:       s.bitmap_pixels_wide = 12'd2048;
          3:       s.bitmap_pixels_wide = 12'hFFF;
          default: s.bitmap_pixels_wide = 12'($urandom);
        endcase
      end
      if ($urandom_range(0, 7) == 0) begin
        s.image_left = 16'($urandom);
        s.image_top  = 16'($urandom);
        s.clip_left  = 16'($urandom);
        s.clip_top   = 16'($urandom);
        s.clip_wide  = 15'($urandom);
        s.clip_tall  = 15'($urandom);
      end
      load_settings(s);
      w = (s.bitmap_pixels_wide > MAX_BITMAP_WIDE) ? 2048 : int'(s.bitmap_pixels_wide);
      per_row = (w + 7) / 8;
      n = (per_row == 0) ? $urandom_range(2, 8) : per_row * $urandom_range(1, 12);
      if (n > 32) n = 32;
      // a broken bitmap carries on into the next one or ends early
      broken = ($urandom_range(0, 4) == 0);
      for (int i = 0; i < n; i++) begin
        fin = (i == n - 1) ? !broken : (broken && $urandom_range(0, 7) == 0);
        send_byte(8'($urandom), fin);
      end
      sent += n;
      drain();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending_writes.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
